// ----- rtl/potb_pkg.sv -----
// Shared types and codes of the periodic/one-shot timer bank.
package potb_pkg;

	// Command codes carried in the func field
	localparam logic [2:0] FUNC_TICK     = 3'd0;
	localparam logic [2:0] FUNC_INIT     = 3'd1;
	localparam logic [2:0] FUNC_START    = 3'd2;
	localparam logic [2:0] FUNC_STOP     = 3'd3;
	localparam logic [2:0] FUNC_MODIFY   = 3'd4;
	localparam logic [2:0] FUNC_DEADLINE = 3'd5;

	// Result kinds
	localparam logic [1:0] KIND_ANSWER   = 2'd0;
	localparam logic [1:0] KIND_EXPIRY   = 2'd1;
	localparam logic [1:0] KIND_DEADLINE = 2'd2;
	localparam logic [1:0] KIND_TICK     = 2'd3;

	// Configuration register indexes
	localparam logic REG_MAX_STEP = 1'b0;
	localparam logic REG_FALLBACK = 1'b1;

	localparam logic [15:0] MAX_STEP_RESET = 16'd1000;
	localparam logic [15:0] FALLBACK_RESET = 16'd10;

	typedef struct packed {
		logic [2:0]         func;
		logic [3:0]         channel;
		logic               one_shot;
		logic [30:0]        interval_ms;
		logic [62:0]        deadline;
		logic signed [31:0] elapsed_ms;
		logic [62:0]        now;
	} item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] which_channel;
		logic       rejected;
		logic       last;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMD_RD,
		ST_CMD_EX,
		ST_TICK_RD,
		ST_TICK_DL,
		ST_TICK_CD,
		ST_TICK_DONE
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic cmd_rd;
		logic walk_rd;
		logic cmd_exec;
		logic dl_check;
		logic cd_check;
		logic tick_done;
	} dp_ctrl_t;

	// Datapath to controller status
	typedef struct packed {
		logic is_tick;
		logic walk_end;
	} dp_status_t;

endpackage

// ----- rtl/potb_ctrl.sv -----
// Sequencing state machine of the timer bank: command and tick walk.
module potb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  potb_pkg::dp_status_t status,
	output potb_pkg::dp_ctrl_t   ctrl
);
	import potb_pkg::*;

	state_t state_q;
	state_t state_next;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_next = status.is_tick ? ST_TICK_RD : ST_CMD_RD;
				end
			end
			ST_CMD_RD:    state_next = ST_CMD_EX;
			ST_CMD_EX:    state_next = ST_IDLE;
			ST_TICK_RD:   state_next = ST_TICK_DL;
			ST_TICK_DL:   state_next = ST_TICK_CD;
			ST_TICK_CD:   state_next = status.walk_end ? ST_TICK_DONE : ST_TICK_DL;
			ST_TICK_DONE: state_next = ST_IDLE;
			default:      state_next = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		ctrl = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy      = 1'b0;
				ctrl.load = start;
			end
			ST_CMD_RD:  ctrl.cmd_rd   = 1'b1;
			ST_CMD_EX:  ctrl.cmd_exec = 1'b1;
			ST_TICK_RD: ctrl.walk_rd  = 1'b1;
			ST_TICK_DL: ctrl.dl_check = 1'b1;
			ST_TICK_CD: begin
				ctrl.cd_check = 1'b1;
				// read the next channel while this one is written back
				ctrl.walk_rd  = !status.walk_end;
			end
			ST_TICK_DONE: ctrl.tick_done = 1'b1;
			default: ;
		endcase
	end

endmodule

// ----- rtl/potb_dp.sv -----
// Datapath of the timer bank: channel state, countdown and deadline checks.
module potb_dp #(
	parameter int CHANNELS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  potb_pkg::dp_ctrl_t   ctrl,
	output potb_pkg::dp_status_t status,
	input  potb_pkg::item_t      item,
	input  logic                 cfg_valid,
	input  logic                 cfg_index,
	input  logic [15:0]          cfg_data,
	output potb_pkg::result_t    result,
	output logic                 result_valid
);
	import potb_pkg::*;

	localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W = $clog2(CHANNELS + 1);

	// Configuration registers
	logic [15:0] max_step_q;
	logic [15:0] fallback_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_step_q <= MAX_STEP_RESET;
			fallback_q <= FALLBACK_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_MAX_STEP) begin
				max_step_q <= cfg_data;
			end else begin
				fallback_q <= cfg_data;
			end
		end
	end

	// Item capture and tick step, replaced by the fallback step when out of range
	item_t       item_q;
	logic [15:0] step_q;
	logic        use_fallback;

	assign use_fallback = item.elapsed_ms[31] || (item.elapsed_ms[30:0] > 31'(max_step_q));

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			item_q <= item;
			step_q <= use_fallback ? fallback_q : item.elapsed_ms[15:0];
		end
	end

	assign status.is_tick = (item.func == FUNC_TICK);

	// Channel walk counter
	logic [CNT_W-1:0] walk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= '0;
		end else if (ctrl.load) begin
			walk_q <= '0;
		end else if (ctrl.walk_rd) begin
			walk_q <= walk_q + 1'b1;
		end
	end

	assign status.walk_end = (walk_q == CNT_W'(CHANNELS));

	// Channel state memories with registered read
	logic [30:0] period_mem [CHANNELS];
	logic [31:0] rem_mem    [CHANNELS];
	logic [62:0] fire_mem   [CHANNELS];

	logic [CW-1:0] rd_addr;
	logic [CW-1:0] idx_q;
	logic [30:0]   period_rd_s1;
	logic [31:0]   rem_rd_s1;
	logic [62:0]   fire_rd_s1;
	logic          rd_en;

	assign rd_en   = ctrl.cmd_rd || ctrl.walk_rd;
	assign rd_addr = ctrl.walk_rd ? walk_q[CW-1:0] : CW'(item_q.channel);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			idx_q        <= rd_addr;
			period_rd_s1 <= period_mem[rd_addr];
			rem_rd_s1    <= rem_mem[rd_addr];
			fire_rd_s1   <= fire_mem[rd_addr];
		end
	end

	// Per-channel flags; the written bits mark memory entries that hold data
	logic [CHANNELS-1:0] cfg_q, run_q, single_q, pv_q, rv_q, fv_q;

	logic [30:0]        period_v;
	logic signed [31:0] rem_v;
	logic [62:0]        fire_v;
	logic               active;

	assign period_v = pv_q[idx_q] ? period_rd_s1 : '0;
	assign rem_v    = rv_q[idx_q] ? rem_rd_s1 : '0;
	assign fire_v   = fv_q[idx_q] ? fire_rd_s1 : '0;
	assign active   = cfg_q[idx_q] && run_q[idx_q];

	// Countdown step with saturation at the most negative value
	logic signed [32:0] diff;
	logic signed [31:0] rem_sub;
	logic signed [31:0] rem_new_q;

	assign diff    = {rem_v[31], rem_v} - $signed({17'b0, step_q});
	assign rem_sub = (diff[32] && !diff[31]) ? 32'sh8000_0000 : diff[31:0];

	always_ff @(posedge clk) begin
		if (ctrl.dl_check) begin
			rem_new_q <= (active && rem_v != 0) ? rem_sub : rem_v;
		end
	end

	// Update decisions for the entry at idx_q
	logic        in_range;
	logic        per_we, rem_we, fire_we;
	logic [30:0] per_wd;
	logic [31:0] rem_wd;
	logic        set_cfg, set_run, clr_run, set_fv, clr_fv;
	logic        emit;
	result_t     res_d;

	assign in_range = (32'(item_q.channel) < CHANNELS);

	always_comb begin
		per_we  = 1'b0;
		rem_we  = 1'b0;
		fire_we = 1'b0;
		per_wd  = item_q.interval_ms;
		rem_wd  = {1'b0, item_q.interval_ms};
		set_cfg = 1'b0;
		set_run = 1'b0;
		clr_run = 1'b0;
		set_fv  = 1'b0;
		clr_fv  = 1'b0;
		emit    = 1'b0;
		res_d   = '0;

		if (ctrl.cmd_exec) begin
			emit                = 1'b1;
			res_d.kind          = KIND_ANSWER;
			res_d.which_channel = item_q.channel;
			res_d.last          = 1'b1;
			res_d.rejected      = 1'b1;
			if (in_range) begin
				unique case (item_q.func)
					FUNC_INIT: begin
						set_cfg        = 1'b1;
						per_we         = 1'b1;
						rem_we         = 1'b1;
						clr_fv         = 1'b1;
						clr_run        = 1'b1;
						res_d.rejected = 1'b0;
					end
					FUNC_START: begin
						if (!run_q[idx_q]) begin
							set_run        = 1'b1;
							rem_we         = 1'b1;
							rem_wd         = {1'b0, period_v};
							res_d.rejected = 1'b0;
						end
					end
					FUNC_STOP: begin
						if (run_q[idx_q]) begin
							clr_run        = 1'b1;
							rem_we         = 1'b1;
							rem_wd         = {1'b0, period_v};
							clr_fv         = 1'b1;
							res_d.rejected = 1'b0;
						end
					end
					FUNC_MODIFY: begin
						if (run_q[idx_q]) begin
							per_we         = 1'b1;
							rem_we         = 1'b1;
							res_d.rejected = 1'b0;
						end
					end
					FUNC_DEADLINE: begin
						if (run_q[idx_q]) begin
							fire_we        = 1'b1;
							set_fv         = 1'b1;
							res_d.rejected = 1'b0;
						end
					end
					default: ;
				endcase
			end
		end else if (ctrl.dl_check) begin
			// deadline reached: report once and clear it
			if (active && fire_v != '0 && item_q.now >= fire_v) begin
				emit                = 1'b1;
				res_d.kind          = KIND_DEADLINE;
				res_d.which_channel = 4'(idx_q);
				clr_fv              = 1'b1;
			end
		end else if (ctrl.cd_check) begin
			if (active) begin
				rem_we = 1'b1;
				rem_wd = rem_new_q;
				if (rem_new_q <= 0) begin
					emit                = 1'b1;
					res_d.kind          = KIND_EXPIRY;
					res_d.which_channel = 4'(idx_q);
					if (single_q[idx_q]) begin
						clr_run = 1'b1;
						clr_fv  = 1'b1;
						rem_wd  = {1'b0, period_v};
					end else begin
						rem_wd = rem_new_q + $signed({1'b0, period_v});
					end
				end
			end
		end else if (ctrl.tick_done) begin
			emit       = 1'b1;
			res_d.kind = KIND_TICK;
			res_d.last = 1'b1;
		end
	end

	// Memory writes
	always_ff @(posedge clk) begin
		if (per_we) begin
			period_mem[idx_q] <= per_wd;
		end
		if (rem_we) begin
			rem_mem[idx_q] <= rem_wd;
		end
		if (fire_we) begin
			fire_mem[idx_q] <= item_q.deadline;
		end
	end

	// Flag updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q    <= '0;
			run_q    <= '0;
			single_q <= '0;
			pv_q     <= '0;
			rv_q     <= '0;
			fv_q     <= '0;
		end else begin
			if (set_cfg) begin
				cfg_q[idx_q]    <= 1'b1;
				single_q[idx_q] <= item_q.one_shot;
			end
			if (set_run) begin
				run_q[idx_q] <= 1'b1;
			end else if (clr_run) begin
				run_q[idx_q] <= 1'b0;
			end
			if (per_we) begin
				pv_q[idx_q] <= 1'b1;
			end
			if (rem_we) begin
				rv_q[idx_q] <= 1'b1;
			end
			if (set_fv) begin
				fv_q[idx_q] <= 1'b1;
			end else if (clr_fv) begin
				fv_q[idx_q] <= 1'b0;
			end
		end
	end

	// Result register
	result_t res_q;
	logic    res_valid_q;

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= emit;
		end
	end

	assign result       = res_q;
	assign result_valid = res_valid_q;

endmodule

// ----- rtl/periodic_oneshot_timer_bank.sv -----
// Top level of the periodic/one-shot timer bank.
//
//  channel   signals                          transfer when
//  -------   -------------------------------  ---------------------------
//  command   start, busy, item                start && !busy
//  result    result_valid, result             result_valid (one cycle)
//  config    cfg_valid, cfg_ready, cfg_index,  cfg_valid && cfg_ready
//            cfg_data
//
// Between transfer and its answer strobe a command passes through a memory
// read of the addressed channel, an update step and the output register.
// A tick walks every channel through a deadline check, then a countdown
// write-back that is overlapped with the read of the next channel.
// busy is high from the cycle after transfer until the last result is registered.
// Reset clears all channel flags; memory contents are masked by written bits.
// Results cannot be held off; config writes are always ready.
module periodic_oneshot_timer_bank #(
	parameter int CHANNELS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  potb_pkg::item_t   item,
	output potb_pkg::result_t result,
	output logic              result_valid,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [15:0]       cfg_data
);
	import potb_pkg::*;

	dp_ctrl_t   ctrl;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	potb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.ctrl   (ctrl)
	);

	potb_dp #(
		.CHANNELS (CHANNELS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.status       (status),
		.item         (item),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result       (result),
		.result_valid (result_valid)
	);

	// An accepted item keeps the block busy in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after command transfer");

	// Tick done is always the final result of its item
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_TICK |-> result.last)
		else $error("tick done without last");

	// Only command answers may be rejected
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.rejected |-> result.kind == KIND_ANSWER)
		else $error("rejected flag on a timer event");

	// Nothing follows the last result directly
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |=> !result_valid)
		else $error("result strobe right after last result");

endmodule

// ----- dv/periodic_oneshot_timer_bank_tb.sv -----
// Self-checking testbench for the periodic/one-shot timer bank: directed and random commands.
module periodic_oneshot_timer_bank_tb;
	import potb_pkg::*;

	localparam int CHANNELS = 16;
	localparam int STALL_LIMIT = 4000;
	localparam int RANDOM_PHASES = 5;
	localparam int ITEMS_PER_PHASE = 50;
	localparam int QUIET_FROM = 210;
	// func values the block must refuse
	localparam logic [2:0] FUNC_UNUSED_6 = 3'd6;
	localparam logic [2:0] FUNC_UNUSED_7 = 3'd7;
	localparam longint REMAIN_FLOOR = -64'sd2147483648;
	localparam logic [62:0] NOW_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

	// Timer bank predictor plus queue of expected results
	class timer_bank_scoreboard;
		bit          configured[CHANNELS];
		bit          running[CHANNELS];
		bit          single_fire[CHANNELS];
		bit [30:0]   period[CHANNELS];
		int          remaining[CHANNELS];
		bit [62:0]   fire_at[CHANNELS];
		logic [15:0] max_step = MAX_STEP_RESET;
		logic [15:0] fallback_step = FALLBACK_RESET;
		result_t     pending_results[$];
		result_t     batch[$];
		int          mismatches = 0;

		task flag_mismatch(string msg);
			mismatches++;
			$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		function int pending();
			return pending_results.size();
		endfunction

		function void write_reg(logic idx, logic [15:0] data);
			if (idx == REG_MAX_STEP)
				max_step = data;
			else
				fallback_step = data;
		endfunction

		function void push_result(logic [1:0] kind, logic [3:0] ch, logic rej);
			result_t r;
			r.kind = kind;
			r.which_channel = ch;
			r.rejected = rej;
			r.last = 1'b0;
			batch.push_back(r);
		endfunction

		function void stop_channel(int c);
			running[c] = 1'b0;
			remaining[c] = int'(period[c]);
			fire_at[c] = '0;
		endfunction

		// Advance the bank by one accepted item and queue what it produces
		task apply_item(item_t it);
			longint el;
			longint stp;
			longint r;
			bit     rej;
			int     ch;
			batch.delete();
			if (it.func == FUNC_TICK) begin
				el = longint'($signed(it.elapsed_ms));
				stp = (el < 0 || el > longint'(max_step)) ? longint'(fallback_step) : el;
				for (int c = 0; c < CHANNELS; c++) begin
					if (!configured[c])
						continue;
					// absolute deadline, one-time
					if (fire_at[c] != 0 && running[c] && it.now >= fire_at[c]) begin
						push_result(KIND_DEADLINE, 4'(c), 1'b0);
						fire_at[c] = '0;
					end
					// countdown, saturating low
					if (remaining[c] != 0 && running[c]) begin
						r = longint'(remaining[c]) - stp;
						if (r < REMAIN_FLOOR)
							r = REMAIN_FLOOR;
						remaining[c] = int'(r);
					end
					if (remaining[c] <= 0 && running[c]) begin
						push_result(KIND_EXPIRY, 4'(c), 1'b0);
						if (single_fire[c])
							stop_channel(c);
						else
							remaining[c] = int'(longint'(remaining[c]) + longint'(period[c]));
					end
				end
				push_result(KIND_TICK, 4'd0, 1'b0);
			end else begin
				rej = 1'b1;
				ch = int'(it.channel);
				case (it.func)
					FUNC_INIT: begin
						configured[ch] = 1'b1;
						single_fire[ch] = it.one_shot;
						period[ch] = it.interval_ms;
						remaining[ch] = int'(it.interval_ms);
						fire_at[ch] = '0;
						running[ch] = 1'b0;
						rej = 1'b0;
					end
					FUNC_START: begin
						if (!running[ch]) begin
							running[ch] = 1'b1;
							remaining[ch] = int'(period[ch]);
							rej = 1'b0;
						end
					end
					FUNC_STOP: begin
						if (running[ch]) begin
							stop_channel(ch);
							rej = 1'b0;
						end
					end
					FUNC_MODIFY: begin
						if (running[ch]) begin
							period[ch] = it.interval_ms;
							remaining[ch] = int'(it.interval_ms);
							rej = 1'b0;
						end
					end
					FUNC_DEADLINE: begin
						if (running[ch]) begin
							fire_at[ch] = it.deadline;
							rej = 1'b0;
						end
					end
					default: ;
				endcase
				push_result(KIND_ANSWER, it.channel, rej);
			end
			batch[batch.size() - 1].last = 1'b1;
			foreach (batch[i])
				pending_results.push_back(batch[i]);
		endtask

		// Compare one strobed result against the oldest expectation
		task check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				flag_mismatch($sformatf("result with nothing expected: kind %0d channel %0d",
					got.kind, got.which_channel));
				return;
			end
			want = pending_results.pop_front();
			if (got.kind !== want.kind)
				flag_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
			if (got.which_channel !== want.which_channel)
				flag_mismatch($sformatf("channel %0d, expected %0d (kind %0d)",
					got.which_channel, want.which_channel, want.kind));
			if (got.rejected !== want.rejected)
				flag_mismatch($sformatf("rejected %0b, expected %0b (channel %0d)",
					got.rejected, want.rejected, want.which_channel));
			if (got.last !== want.last)
				flag_mismatch($sformatf("last %0b, expected %0b (kind %0d channel %0d)",
					got.last, want.last, want.kind, want.which_channel));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	item_t       item = '0;
	result_t     result;
	logic        result_valid;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = REG_MAX_STEP;
	logic [15:0] cfg_data = '0;

	timer_bank_scoreboard sb = new();
	logic [62:0] mono_now = 63'd1000;
	int          quiet_cycles = 0;

	periodic_oneshot_timer_bank #(.CHANNELS(CHANNELS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result(result),
		.result_valid(result_valid),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Observe transfers on all three channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid)
				sb.check_result(result);
			if (start && !busy)
				sb.apply_item(item);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
		end
	end

	// Watchdog on cycles with no transfer of any kind
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic item_t random_fill();
		logic [223:0] noise;
		noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		return noise[$bits(item_t)-1:0];
	endfunction

	task automatic send_item(item_t it);
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
	endtask

	// Random burst of idle cycles on the command side
	task automatic sender_gap();
		if ($urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic send_cmd(logic [2:0] fn, logic [3:0] ch, logic os, logic [30:0] iv,
		logic [62:0] dl);
		item_t it;
		it = random_fill();
		it.func = fn;
		it.channel = ch;
		it.one_shot = os;
		it.interval_ms = iv;
		it.deadline = dl;
		send_item(it);
		sender_gap();
	endtask

	task automatic send_tick(logic [31:0] el, logic [62:0] nw);
		item_t it;
		it = random_fill();
		it.func = FUNC_TICK;
		it.elapsed_ms = el;
		it.now = nw;
		send_item(it);
		sender_gap();
	endtask

	// Wait for the bank to drain, then write both step registers in one burst
	task automatic write_steps(logic [15:0] max_step, logic [15:0] fallback);
		start <= 1'b0;
		// wait so that a transfer at the previous edge is already on the scoreboard
		@(posedge clk);
		while (sb.pending() != 0 || busy) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= REG_MAX_STEP;
		cfg_data <= max_step;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_FALLBACK;
		cfg_data <= fallback;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [30:0] pick_interval();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return '0;
		if (sel <= 2)
			return 31'($urandom);
		return 31'($urandom_range(1, 120));
	endfunction

	// Mostly well-formed timer traffic on a moving time base, some noise
	function automatic item_t next_random_item();
		item_t it;
		int    sel;
		int    pick;
		it = random_fill();
		it.channel = 4'($urandom_range(0, CHANNELS - 1));
		sel = $urandom_range(0, 99);
		if (sel < 40) begin
			it.func = FUNC_TICK;
			pick = $urandom_range(0, 9);
			if (pick <= 5)
				it.elapsed_ms = 32'($urandom_range(0, 40));
			else if (pick == 6)
				it.elapsed_ms = 32'(sb.max_step) + 32'($urandom_range(0, 2)) - 32'd1;
			else if (pick == 7)
				it.elapsed_ms = $urandom | 32'h8000_0000;
			// otherwise keep the fully random step
			if ($urandom_range(0, 19) != 0) begin
				mono_now = mono_now + 63'($urandom_range(0, 40));
				it.now = mono_now;
			end
		end else if (sel < 55) begin
			it.func = FUNC_INIT;
			it.interval_ms = pick_interval();
		end else if (sel < 72) begin
			it.func = FUNC_START;
		end else if (sel < 82) begin
			it.func = FUNC_STOP;
		end else if (sel < 90) begin
			it.func = FUNC_MODIFY;
			it.interval_ms = pick_interval();
		end else if (sel < 97) begin
			it.func = FUNC_DEADLINE;
			pick = $urandom_range(0, 19);
			if (pick < 12)
				it.deadline = mono_now + 63'($urandom_range(0, 100));
			else if (pick < 15)
				it.deadline = '0;
		end else begin
			it.func = ($urandom_range(0, 1) == 0) ? FUNC_UNUSED_6 : FUNC_UNUSED_7;
		end
		return it;
	endfunction

	// Edge cases: empty bank, accept/reject rules, zero and max intervals, fallback step
	task automatic run_directed();
		send_tick(32'd5, 63'd100);
		send_cmd(FUNC_START, 4'd3, 1'b0, '0, '0);
		send_cmd(FUNC_STOP, 4'd3, 1'b0, '0, '0);
		send_cmd(FUNC_STOP, 4'd3, 1'b0, '0, '0);
		send_cmd(FUNC_INIT, 4'd0, 1'b0, 31'd0, '0);
		send_cmd(FUNC_START, 4'd0, 1'b0, '0, '0);
		send_cmd(FUNC_START, 4'd0, 1'b0, '0, '0);
		send_cmd(FUNC_INIT, 4'd15, 1'b1, 31'h7FFF_FFFF, '0);
		send_cmd(FUNC_MODIFY, 4'd15, 1'b0, 31'd5, '0);
		send_cmd(FUNC_DEADLINE, 4'd15, 1'b0, '0, 63'd150);
		send_cmd(FUNC_START, 4'd15, 1'b0, '0, '0);
		send_cmd(FUNC_MODIFY, 4'd15, 1'b0, 31'd30, '0);
		send_cmd(FUNC_DEADLINE, 4'd15, 1'b0, '0, 63'd150);
		send_cmd(FUNC_INIT, 4'd1, 1'b1, 31'd20, '0);
		send_cmd(FUNC_START, 4'd1, 1'b0, '0, '0);
		send_tick(32'd20, 63'd149);
		send_tick(32'h8000_0000, 63'd150);
		send_tick(32'h7FFF_FFFF, NOW_MAX);
		send_tick(32'(MAX_STEP_RESET), 63'd200);
		send_cmd(FUNC_DEADLINE, 4'd0, 1'b0, '0, NOW_MAX);
		send_tick(32'd0, NOW_MAX);
		send_cmd(FUNC_UNUSED_6, 4'd7, 1'b0, '0, '0);
		send_cmd(FUNC_UNUSED_7, 4'd15, 1'b0, '0, '0);
		send_cmd(FUNC_STOP, 4'd0, 1'b0, '0, '0);
		send_cmd(FUNC_DEADLINE, 4'd0, 1'b0, '0, 63'd1);
	endtask

	initial begin
		logic [15:0] max_step;
		logic [15:0] fallback;
		int          sent;
		sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();

		// Random phases, each under its own step settings
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: begin max_step = 16'd0; fallback = 16'd0; end
				1: begin max_step = 16'hFFFF; fallback = 16'hFFFF; end
				2: begin max_step = MAX_STEP_RESET; fallback = FALLBACK_RESET; end
				3: begin
					max_step = 16'($urandom_range(0, 200));
					fallback = 16'($urandom_range(0, 50));
				end
				default: begin max_step = 16'd30; fallback = 16'd1; end
			endcase
			write_steps(max_step, fallback);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				send_item(next_random_item());
				sent++;
				if (sent < QUIET_FROM)
					sender_gap();
			end
		end

		// Drain and let any stray results show up
		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/potb_pkg.sv
rtl/potb_ctrl.sv
rtl/potb_dp.sv
rtl/periodic_oneshot_timer_bank.sv
dv/periodic_oneshot_timer_bank_tb.sv
